// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file rwsl_checker.sv.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define RWSL_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// next-cycle implication, disabled in reset
`define RWSL_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// ===== rtl/core/rwsl_pkg.sv =====
// ----------------------------------------------------------------------------
// rwsl_pkg
// Types, sizes and helpers for the reader/writer slot lock arbiter.
// ----------------------------------------------------------------------------
package rwsl_pkg;

  localparam int ID_W           = 16;
  localparam int MAX_READ_SLOTS = 8;
  localparam int WAIT_DEPTH     = 16;

  localparam int FUNC_W     = 2;
  localparam int STATUS_W   = 3;
  localparam int SLOT_W     = 4;
  localparam int CFG_W      = 4;
  localparam int SLOT_IDX_W = (MAX_READ_SLOTS > 1) ? $clog2(MAX_READ_SLOTS) : 1;
  localparam int PTR_W      = $clog2(WAIT_DEPTH);
  localparam int CNT_W      = $clog2(WAIT_DEPTH + 1);

  localparam logic [CNT_W-1:0] FIFO_FULL_COUNT = CNT_W'(WAIT_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST        = PTR_W'(WAIT_DEPTH - 1);
  localparam logic [CFG_W-1:0] CFG_SLOTS_MAX   = CFG_W'(MAX_READ_SLOTS);
  localparam logic [CFG_W-1:0] CFG_SLOTS_RESET = CFG_W'(4);

  typedef enum logic [FUNC_W-1:0] {
    FN_READ    = 2'd0,
    FN_WRITE   = 2'd1,
    FN_RELEASE = 2'd2,
    FN_LOCATE  = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_GRANTED  = 3'd0,
    ST_QUEUED   = 3'd1,
    ST_IDLE     = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FULL     = 3'd4,
    ST_LOCATED  = 3'd5
  } status_t;

  typedef enum logic {
    S_WAIT = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic                  free_hit;
    logic [SLOT_IDX_W-1:0] free_idx;
    logic                  id_hit;
    logic [SLOT_IDX_W-1:0] id_idx;
    logic                  wr_match;
    logic                  wr_empty;
  } slot_search_t;

  typedef struct packed {
    logic                  rd_we;
    logic [SLOT_IDX_W-1:0] rd_idx;
    logic [ID_W-1:0]       rd_data;
    logic                  wr_we;
    logic [ID_W-1:0]       wr_data;
  } slot_update_t;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    r = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    return r;
  endfunction

endpackage

// ===== rtl/core/rwsl_wait_fifo.sv =====
// ----------------------------------------------------------------------------
// rwsl_wait_fifo
// Wait queue of ids in a synchronous memory; the head word is read into a
// register on rd_en.
// ----------------------------------------------------------------------------
module rwsl_wait_fifo (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       rd_en,
  input  logic                       push,
  input  logic [rwsl_pkg::ID_W-1:0]  push_data,
  input  logic                       pop,
  output logic [rwsl_pkg::ID_W-1:0]  head_data,
  output logic                       nonempty,
  output logic                       full
);

  logic [rwsl_pkg::ID_W-1:0]  mem [rwsl_pkg::WAIT_DEPTH];
  logic [rwsl_pkg::PTR_W-1:0] head;
  logic [rwsl_pkg::PTR_W-1:0] tail;
  logic [rwsl_pkg::CNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[tail] <= push_data;
    end
    if (rd_en) begin
      head_data <= mem[head];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail  <= rwsl_pkg::ptr_inc(tail);
        count <= count + rwsl_pkg::CNT_W'(1);
      end else if (pop) begin
        head  <= rwsl_pkg::ptr_inc(head);
        count <= count - rwsl_pkg::CNT_W'(1);
      end
    end
  end

  assign nonempty = (count != '0);
  assign full     = (count == rwsl_pkg::FIFO_FULL_COUNT);

endmodule

// ===== rtl/core/rwsl_slot_bank.sv =====
// ----------------------------------------------------------------------------
// rwsl_slot_bank
// Read and write slot owners with parallel lowest-index search.
// ----------------------------------------------------------------------------
module rwsl_slot_bank (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [rwsl_pkg::CFG_W-1:0]    num_slots,
  input  logic [rwsl_pkg::ID_W-1:0]     key,
  input  rwsl_pkg::slot_update_t        upd,
  output rwsl_pkg::slot_search_t        search
);

  logic [rwsl_pkg::ID_W-1:0]  owner [rwsl_pkg::MAX_READ_SLOTS];
  logic [rwsl_pkg::ID_W-1:0]  wr_owner;
  logic [rwsl_pkg::CFG_W-1:0] n;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < rwsl_pkg::MAX_READ_SLOTS; i++) begin
        owner[i] <= '0;
      end
      wr_owner <= '0;
    end else begin
      if (upd.rd_we) begin
        owner[upd.rd_idx] <= upd.rd_data;
      end
      if (upd.wr_we) begin
        wr_owner <= upd.wr_data;
      end
    end
  end

  always_comb begin
    if (num_slots == '0) begin
      n = rwsl_pkg::CFG_W'(1);
    end else if (num_slots > rwsl_pkg::CFG_SLOTS_MAX) begin
      n = rwsl_pkg::CFG_SLOTS_MAX;
    end else begin
      n = num_slots;
    end

    search          = '0;
    search.wr_match = (wr_owner == key);
    search.wr_empty = (wr_owner == '0);
    for (int i = rwsl_pkg::MAX_READ_SLOTS - 1; i >= 0; i--) begin
      if (rwsl_pkg::CFG_W'(i) < n) begin
        if (owner[i] == '0) begin
          search.free_hit = 1'b1;
          search.free_idx = rwsl_pkg::SLOT_IDX_W'(i);
        end
        if (owner[i] == key) begin
          search.id_hit = 1'b1;
          search.id_idx = rwsl_pkg::SLOT_IDX_W'(i);
        end
      end
    end
  end

endmodule

// ===== rtl/core/reader_writer_slot_lock_arbiter.sv =====
// ----------------------------------------------------------------------------
// reader_writer_slot_lock_arbiter
// Grants one write slot and a set of read slots to requester ids, with FIFO
// wait queues for readers and writers.
// ----------------------------------------------------------------------------
// Result: the accepting edge moves the FSM to S_EXEC, and done and the result
//   word are then registered together as S_EXEC ends.
// Busy is high in S_EXEC, which covers the wait-queue head read returning and
//   the slots and queues being updated; start is not accepted while busy.
// Reset (rst, synchronous): all slots empty, both queues empty, read slot
//   count 4. The receiver cannot stall; each result is shown for one cycle.
module reader_writer_slot_lock_arbiter (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [rwsl_pkg::CFG_W-1:0]    cfg_data,
  input  logic                          start,
  output logic                          busy,
  input  logic [rwsl_pkg::FUNC_W-1:0]   func,
  input  logic [rwsl_pkg::ID_W-1:0]     context_id,
  output logic                          done,
  output logic [rwsl_pkg::STATUS_W-1:0] status,
  output logic                          granted,
  output logic [rwsl_pkg::ID_W-1:0]     granted_id,
  output logic [rwsl_pkg::SLOT_W-1:0]   slot
);

  rwsl_pkg::state_t              state, state_next;
  logic [rwsl_pkg::CFG_W-1:0]    num_slots;
  rwsl_pkg::func_t               func_q;
  logic [rwsl_pkg::ID_W-1:0]     id_q;
  logic                          accept;
  logic                          exec;

  rwsl_pkg::slot_search_t        search;
  rwsl_pkg::slot_update_t        upd;

  logic                          rq_push, rq_pop, rq_nonempty, rq_full;
  logic                          wq_push, wq_pop, wq_nonempty, wq_full;
  logic [rwsl_pkg::ID_W-1:0]     rq_head, wq_head;

  rwsl_pkg::status_t             status_next;
  logic                          granted_next;
  logic [rwsl_pkg::ID_W-1:0]     granted_id_next;
  logic [rwsl_pkg::SLOT_W-1:0]   slot_next;

  assign accept = start && !busy;
  assign exec   = (state == rwsl_pkg::S_EXEC);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rwsl_pkg::S_WAIT;
      num_slots <= rwsl_pkg::CFG_SLOTS_RESET;
      done      <= 1'b0;
    end else begin
      state <= state_next;
      done  <= exec;
      if (cfg_we) begin
        num_slots <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_q <= rwsl_pkg::func_t'(func);
      id_q   <= context_id;
    end
    if (exec) begin
      status     <= status_next;
      granted    <= granted_next;
      granted_id <= granted_id_next;
      slot       <= slot_next;
    end
  end

  always_comb begin
    state_next = state;
    busy       = 1'b0;
    unique case (state)
      rwsl_pkg::S_WAIT: begin
        if (start) state_next = rwsl_pkg::S_EXEC;
      end
      rwsl_pkg::S_EXEC: begin
        busy       = 1'b1;
        state_next = rwsl_pkg::S_WAIT;
      end
      default: state_next = rwsl_pkg::S_WAIT;
    endcase
  end

  always_comb begin
    upd             = '0;
    rq_push         = 1'b0;
    rq_pop          = 1'b0;
    wq_push         = 1'b0;
    wq_pop          = 1'b0;
    status_next     = rwsl_pkg::ST_NOTFOUND;
    granted_next    = 1'b0;
    granted_id_next = '0;
    slot_next       = '0;
    if (exec && id_q != '0) begin
      unique case (func_q)
        rwsl_pkg::FN_READ: begin
          if (!rq_nonempty && search.free_hit) begin
            upd.rd_we       = 1'b1;
            upd.rd_idx      = search.free_idx;
            upd.rd_data     = id_q;
            status_next     = rwsl_pkg::ST_GRANTED;
            granted_next    = 1'b1;
            granted_id_next = id_q;
            slot_next       = rwsl_pkg::SLOT_W'(search.free_idx) + rwsl_pkg::SLOT_W'(1);
          end else if (!rq_full) begin
            rq_push     = 1'b1;
            status_next = rwsl_pkg::ST_QUEUED;
          end else begin
            status_next = rwsl_pkg::ST_FULL;
          end
        end
        rwsl_pkg::FN_WRITE: begin
          if (search.wr_empty) begin
            upd.wr_we       = 1'b1;
            upd.wr_data     = id_q;
            status_next     = rwsl_pkg::ST_GRANTED;
            granted_next    = 1'b1;
            granted_id_next = id_q;
          end else if (!wq_full) begin
            wq_push     = 1'b1;
            status_next = rwsl_pkg::ST_QUEUED;
          end else begin
            status_next = rwsl_pkg::ST_FULL;
          end
        end
        rwsl_pkg::FN_RELEASE: begin
          if (search.wr_match) begin
            upd.wr_we = 1'b1;
            if (wq_nonempty) begin
              wq_pop          = 1'b1;
              upd.wr_data     = wq_head;
              status_next     = rwsl_pkg::ST_GRANTED;
              granted_next    = 1'b1;
              granted_id_next = wq_head;
            end else begin
              upd.wr_data = '0;
              status_next = rwsl_pkg::ST_IDLE;
            end
          end else if (search.id_hit) begin
            upd.rd_we  = 1'b1;
            upd.rd_idx = search.id_idx;
            slot_next  = rwsl_pkg::SLOT_W'(search.id_idx) + rwsl_pkg::SLOT_W'(1);
            if (rq_nonempty) begin
              rq_pop          = 1'b1;
              upd.rd_data     = rq_head;
              status_next     = rwsl_pkg::ST_GRANTED;
              granted_next    = 1'b1;
              granted_id_next = rq_head;
            end else begin
              upd.rd_data = '0;
              status_next = rwsl_pkg::ST_IDLE;
            end
          end
        end
        rwsl_pkg::FN_LOCATE: begin
          if (search.wr_match) begin
            status_next = rwsl_pkg::ST_LOCATED;
          end else if (search.id_hit) begin
            status_next = rwsl_pkg::ST_LOCATED;
            slot_next   = rwsl_pkg::SLOT_W'(search.id_idx) + rwsl_pkg::SLOT_W'(1);
          end
        end
        default: status_next = rwsl_pkg::ST_NOTFOUND;
      endcase
    end
  end

  rwsl_slot_bank u_slots (
    .clk       (clk),
    .rst       (rst),
    .num_slots (num_slots),
    .key       (id_q),
    .upd       (upd),
    .search    (search)
  );

  rwsl_wait_fifo u_reader_q (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (accept),
    .push      (rq_push),
    .push_data (id_q),
    .pop       (rq_pop),
    .head_data (rq_head),
    .nonempty  (rq_nonempty),
    .full      (rq_full)
  );

  rwsl_wait_fifo u_writer_q (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (accept),
    .push      (wq_push),
    .push_data (id_q),
    .pop       (wq_pop),
    .head_data (wq_head),
    .nonempty  (wq_nonempty),
    .full      (wq_full)
  );

endmodule

// ===== rtl/core/rwsl_checker.sv =====
// ----------------------------------------------------------------------------
// rwsl_checker
// Port-level checks of the slot lock arbiter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rwsl_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          done,
  input logic [rwsl_pkg::STATUS_W-1:0] status,
  input logic                          granted,
  input logic [rwsl_pkg::ID_W-1:0]     granted_id
);

  `RWSL_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
  `RWSL_ASSERT_NEXT(a_busy_done, clk, rst, busy, done && !busy)
  `RWSL_ASSERT_NOW(a_status_code, clk, rst, done, status <= rwsl_pkg::ST_LOCATED)
  `RWSL_ASSERT_NOW(a_grant_id, clk, rst, done, granted == (granted_id != '0))
  `RWSL_ASSERT_NOW(a_grant_status, clk, rst, done && granted, status == rwsl_pkg::ST_GRANTED)

endmodule

bind reader_writer_slot_lock_arbiter rwsl_checker u_rwsl_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .done       (done),
  .status     (status),
  .granted    (granted),
  .granted_id (granted_id)
);
